// ----- sv/bilinear_image_resize_core_macros.svh -----
// Assertion macros for the bilinear image resize core.
// Included by the modules that carry concurrent checks; depends on clk and rst_n.
`ifndef BILINEAR_IMAGE_RESIZE_CORE_MACROS_SVH
`define BILINEAR_IMAGE_RESIZE_CORE_MACROS_SVH
`ifndef SYNTH
`define BIR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define BIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define BIR_ASSERT_SAME(lbl, ante, cons)
`define BIR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/bir_pkg.sv -----
// Shared constants and types of the bilinear image resize core.
// No dependencies; imported by every module of the core except bir_ram.
package bir_pkg;
    localparam int SRC_W_BITS = 8;
    localparam int SRC_H_BITS = 8;
    localparam int CH_BITS    = 2;
    localparam int FRAC_BITS  = 16;
    localparam int DST_BITS   = 12;
    localparam int STEP_BITS  = SRC_W_BITS + FRAC_BITS;
    localparam int POS_BITS   = DST_BITS + STEP_BITS;
    localparam int ADDR_BITS  = SRC_H_BITS + SRC_W_BITS + CH_BITS;
    localparam int WGT_BITS   = FRAC_BITS + 1;
    localparam int HSUM_BITS  = 8 + FRAC_BITS;
    localparam int VSUM_BITS  = 8 + 2 * FRAC_BITS;
    localparam logic [WGT_BITS-1:0] ONE = WGT_BITS'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_CHANNELS   = 3'd2,
        REG_DST_WIDTH  = 3'd3,
        REG_DST_HEIGHT = 3'd4
    } cfg_index_t;

    // One word handed from the front stage to the read sequencer.
    typedef struct packed {
        logic                  is_load;
        logic                  load_ok;
        logic                  err;
        logic [CH_BITS-1:0]    ch;
        logic [SRC_W_BITS-1:0] xl;
        logic [SRC_W_BITS-1:0] xh;
        logic [SRC_H_BITS-1:0] yl;
        logic [SRC_H_BITS-1:0] yh;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fy;
        logic [7:0]            value;
    } bir_item_t;
endpackage

// ----- sv/bilinear_image_resize_core.sv -----
// Top level of the bilinear image resize core: configuration, step dividers and front stage.
// Depends on bir_pkg, bir_div and bir_interp.
//
//  channel  | ports                                     | handshake
//  ---------+-------------------------------------------+-------------------------
//  input    | cmd, row, col, channel, pixel_value       | start high, busy low
//  result   | result_value, range_error                 | result_valid, one cycle
//  config   | cfg_index, cfg_data                       | cfg_we, no wait
//
// A compute word holds the single pixel RAM port for its four neighbor reads before the
// next compute is taken; loads and out-of-range computes pass without reads. After the
// last neighbor read, the result passes the RAM read register, the horizontal weighting
// registers and the output registers. After reset and after every configuration write,
// busy stays high while the two axis steps are divided. The result side cannot stall.
module bilinear_image_resize_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [12:0]                  cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [bir_pkg::DST_BITS-1:0] row,
    input  logic [bir_pkg::DST_BITS-1:0] col,
    input  logic [bir_pkg::CH_BITS-1:0]  channel,
    input  logic [7:0]                   pixel_value,
    output logic                         result_valid,
    output logic [7:0]                   result_value,
    output logic                         range_error
);
    import bir_pkg::*;

    logic [8:0]            src_width_reg;
    logic [8:0]            src_height_reg;
    logic [2:0]            channels_reg;
    logic [12:0]           dst_width_reg;
    logic [12:0]           dst_height_reg;
    logic                  dirty_reg;
    logic [8:0]            sw_eff;
    logic [8:0]            sh_eff;
    logic [2:0]            nc_eff;
    logic [12:0]           dw_eff;
    logic [12:0]           dh_eff;
    logic [SRC_W_BITS-1:0] sw_m1;
    logic [SRC_H_BITS-1:0] sh_m1;
    logic                  div_x_busy;
    logic                  div_y_busy;
    logic [STEP_BITS-1:0]  step_x;
    logic [STEP_BITS-1:0]  step_y;
    logic                  accept;
    logic                  item_ready;
    logic                  s1_valid_reg;
    logic                  s1_load_reg;
    logic                  s1_ok_reg;
    logic                  s1_err_reg;
    logic [CH_BITS-1:0]    s1_ch_reg;
    logic [7:0]            s1_value_reg;
    logic [SRC_H_BITS-1:0] s1_row_reg;
    logic [SRC_W_BITS-1:0] s1_col_reg;
    logic [POS_BITS-1:0]   pos_x_reg;
    logic [POS_BITS-1:0]   pos_y_reg;
    logic [POS_BITS-FRAC_BITS-1:0] ix;
    logic [POS_BITS-FRAC_BITS-1:0] iy;
    logic [SRC_W_BITS-1:0] xl;
    logic [SRC_H_BITS-1:0] yl;
    bir_item_t             item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 9'd256;
            src_height_reg <= 9'd256;
            channels_reg   <= 3'd3;
            dst_width_reg  <= 13'd80;
            dst_height_reg <= 13'd40;
            dirty_reg      <= 1'b1;
        end
        else
        begin
            dirty_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SRC_WIDTH:  src_width_reg  <= cfg_data[8:0];
                    REG_SRC_HEIGHT: src_height_reg <= cfg_data[8:0];
                    REG_CHANNELS:   channels_reg   <= cfg_data[2:0];
                    REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                    REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Effective sizes, saturated into their legal ranges.
    always_comb
    begin
        sw_eff = (src_width_reg == '0) ? 9'd1 : (src_width_reg > 9'd256) ? 9'd256
               : src_width_reg;
        sh_eff = (src_height_reg == '0) ? 9'd1 : (src_height_reg > 9'd256) ? 9'd256
               : src_height_reg;
        nc_eff = (channels_reg == '0) ? 3'd1 : (channels_reg > 3'd4) ? 3'd4 : channels_reg;
        dw_eff = (dst_width_reg == '0) ? 13'd1 : (dst_width_reg > 13'd4096) ? 13'd4096
               : dst_width_reg;
        dh_eff = (dst_height_reg == '0) ? 13'd1 : (dst_height_reg > 13'd4096) ? 13'd4096
               : dst_height_reg;
        sw_m1  = SRC_W_BITS'(sw_eff - 9'd1);
        sh_m1  = SRC_H_BITS'(sh_eff - 9'd1);
    end

    // Axis steps; a destination size of one gives a zero divisor and a zero step.
    bir_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dirty_reg),
        .dividend ({sw_m1, {FRAC_BITS{1'b0}}}),
        .divisor  (DST_BITS'(dw_eff - 13'd1)),
        .busy     (div_x_busy),
        .quotient (step_x)
    );

    bir_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dirty_reg),
        .dividend ({sh_m1, {FRAC_BITS{1'b0}}}),
        .divisor  (DST_BITS'(dh_eff - 13'd1)),
        .busy     (div_y_busy),
        .quotient (step_y)
    );

    assign busy   = dirty_reg || div_x_busy || div_y_busy || (s1_valid_reg && !item_ready);
    assign accept = start && !busy;

    // Front stage: range checks and the position multiplies.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_load_reg  <= !cmd;
            s1_ok_reg    <= ({1'b0, row} < {4'd0, sh_eff}) && ({1'b0, col} < {4'd0, sw_eff})
                          && ({1'b0, channel} < nc_eff);
            s1_err_reg   <= cmd && (({1'b0, row} >= dh_eff) || ({1'b0, col} >= dw_eff)
                          || ({1'b0, channel} >= nc_eff));
            s1_ch_reg    <= channel;
            s1_value_reg <= pixel_value;
            s1_row_reg   <= row[SRC_H_BITS-1:0];
            s1_col_reg   <= col[SRC_W_BITS-1:0];
            pos_x_reg    <= POS_BITS'(col * step_x);
            pos_y_reg    <= POS_BITS'(row * step_y);
        end
    end

    // Split positions into clamped neighbor indices and fractions.
    assign ix = pos_x_reg[POS_BITS-1:FRAC_BITS];
    assign iy = pos_y_reg[POS_BITS-1:FRAC_BITS];
    assign xl = (ix > (POS_BITS-FRAC_BITS)'(sw_m1)) ? sw_m1 : ix[SRC_W_BITS-1:0];
    assign yl = (iy > (POS_BITS-FRAC_BITS)'(sh_m1)) ? sh_m1 : iy[SRC_H_BITS-1:0];

    always_comb
    begin
        item.is_load = s1_load_reg;
        item.load_ok = s1_ok_reg;
        item.err     = s1_err_reg;
        item.ch      = s1_ch_reg;
        item.value   = s1_value_reg;
        item.fx      = pos_x_reg[FRAC_BITS-1:0];
        item.fy      = pos_y_reg[FRAC_BITS-1:0];
        if (s1_load_reg)
        begin
            item.xl = s1_col_reg;
            item.yl = s1_row_reg;
        end
        else
        begin
            item.xl = xl;
            item.yl = yl;
        end
        item.xh = ((item.fx != '0) && (xl != sw_m1)) ? xl + 1'b1 : xl;
        item.yh = ((item.fy != '0) && (yl != sh_m1)) ? yl + 1'b1 : yl;
    end

    bir_interp u_interp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s1_valid_reg),
        .item         (item),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_value (result_value),
        .range_error  (range_error)
    );
endmodule

// ----- sv/bir_div.sv -----
// Restoring divider, one quotient bit per cycle, for the axis step.
// Depends on bir_pkg.
module bir_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bir_pkg::STEP_BITS-1:0] dividend,
    input  logic [bir_pkg::DST_BITS-1:0]  divisor,
    output logic                          busy,
    output logic [bir_pkg::STEP_BITS-1:0] quotient
);
    import bir_pkg::*;
    localparam int CNT_BITS = $clog2(STEP_BITS);

    logic                 run_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [DST_BITS-1:0]  rem_reg;
    logic [STEP_BITS-1:0] quo_reg;
    logic [STEP_BITS-1:0] dvd_reg;
    logic [DST_BITS-1:0]  dvs_reg;
    logic [DST_BITS:0]    trial;
    logic                 ge;

    // Trial subtraction of one step.
    assign trial = {rem_reg, dvd_reg[STEP_BITS-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= (divisor != '0);
            cnt_reg <= CNT_BITS'(STEP_BITS - 1);
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Datapath of the iteration.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? DST_BITS'(trial - {1'b0, dvs_reg}) : trial[DST_BITS-1:0];
            quo_reg <= {quo_reg[STEP_BITS-2:0], ge};
            dvd_reg <= {dvd_reg[STEP_BITS-2:0], 1'b0};
        end
    end

    assign busy     = run_reg;
    assign quotient = quo_reg;
endmodule

// ----- sv/bir_ram.sv -----
// Single-port synchronous RAM with registered read data.
// No dependencies.
module bir_ram #(
    parameter int ADDR_W = 18,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- sv/bir_interp.sv -----
// Read sequencer over the pixel store and the two-stage bilinear weighting.
// Depends on bir_pkg, bir_ram and the assertion macro header.
`include "bilinear_image_resize_core_macros.svh"
module bir_interp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  bir_pkg::bir_item_t item,
    output logic               item_ready,
    output logic               result_valid,
    output logic [7:0]         result_value,
    output logic               range_error
);
    import bir_pkg::*;

    bir_item_t                s2_reg;
    logic                     s2_valid_reg;
    logic [1:0]               phase_reg;
    logic                     s2_last;
    logic                     item_take;
    logic                     ram_we;
    logic                     ram_re;
    logic [ADDR_BITS-1:0]     ram_addr;
    logic [7:0]               rdata;
    logic [1:0]               rd_phase_reg;
    logic                     tok_valid_reg;
    logic                     tok_err_reg;
    logic [FRAC_BITS-1:0]     tok_fx_reg;
    logic [FRAC_BITS-1:0]     tok_fy_reg;
    logic [7:0]               pix_reg [3];
    logic                     s4_valid_reg;
    logic                     s4_err_reg;
    logic [HSUM_BITS-1:0]     top_reg;
    logic [HSUM_BITS-1:0]     bot_reg;
    logic [FRAC_BITS-1:0]     s4_fy_reg;
    logic [WGT_BITS-1:0]      wx0;
    logic [WGT_BITS-1:0]      wx1;
    logic [WGT_BITS-1:0]      wy0;
    logic [WGT_BITS-1:0]      wy1;
    logic [VSUM_BITS-1:0]     vsum;
    logic [VSUM_BITS-FRAC_BITS*2-1:0] vint;
    logic                     out_valid_reg;
    logic [7:0]               out_value_reg;
    logic                     out_err_reg;

    // A load or an error word finishes at once, a compute word after four reads.
    assign s2_last    = s2_reg.is_load || s2_reg.err || (phase_reg == 2'd3);
    assign item_ready = !s2_valid_reg || s2_last;
    assign item_take  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            phase_reg    <= '0;
        end
        else
        begin
            if (item_take)
            begin
                s2_valid_reg <= 1'b1;
                phase_reg    <= '0;
            end
            else
            begin
                if (s2_valid_reg && s2_last)
                begin
                    s2_valid_reg <= 1'b0;
                end
                if (s2_valid_reg)
                begin
                    phase_reg <= phase_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s2_reg <= item;
        end
    end

    // Address of the neighbor for the current read phase.
    always_comb
    begin
        ram_we   = s2_valid_reg && s2_reg.is_load && s2_reg.load_ok;
        ram_re   = s2_valid_reg && !s2_reg.is_load && !s2_reg.err;
        ram_addr = {s2_reg.yl, s2_reg.xl, s2_reg.ch};
        if (!s2_reg.is_load)
        begin
            case (phase_reg)
                2'd0:    ram_addr = {s2_reg.yl, s2_reg.xl, s2_reg.ch};
                2'd1:    ram_addr = {s2_reg.yl, s2_reg.xh, s2_reg.ch};
                2'd2:    ram_addr = {s2_reg.yh, s2_reg.xl, s2_reg.ch};
                default: ram_addr = {s2_reg.yh, s2_reg.xh, s2_reg.ch};
            endcase
        end
    end

    bir_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (8)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s2_reg.value),
        .rdata (rdata)
    );

    // Track which neighbor the RAM returns in the following cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= s2_valid_reg && !s2_reg.is_load && s2_last;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_phase_reg <= phase_reg;
        tok_err_reg  <= s2_reg.err;
        tok_fx_reg   <= s2_reg.fx;
        tok_fy_reg   <= s2_reg.fy;
    end

    // Collect the first three neighbors; the fourth is used straight from the RAM.
    always_ff @(posedge clk)
    begin
        if (rd_phase_reg != 2'd3)
        begin
            pix_reg[rd_phase_reg] <= rdata;
        end
    end

    // Horizontal weighting of both rows.
    assign wx1 = {1'b0, tok_fx_reg};
    assign wx0 = ONE - wx1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= tok_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_err_reg <= tok_err_reg;
        s4_fy_reg  <= tok_fy_reg;
        top_reg    <= HSUM_BITS'(pix_reg[0] * wx0 + pix_reg[1] * wx1);
        bot_reg    <= HSUM_BITS'(pix_reg[2] * wx0 + rdata * wx1);
    end

    // Vertical weighting and truncation.
    assign wy1  = {1'b0, s4_fy_reg};
    assign wy0  = ONE - wy1;
    assign vsum = VSUM_BITS'(top_reg * wy0 + bot_reg * wy1);
    assign vint = vsum[VSUM_BITS-1:2*FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_err_reg   <= s4_err_reg;
        out_value_reg <= s4_err_reg ? 8'd0 : vint[7:0];
    end

    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;
    assign range_error  = out_err_reg;

    `BIR_ASSERT_NEXT(a_result_follows_token, s4_valid_reg, result_valid)
    `BIR_ASSERT_SAME(a_error_reads_zero, result_valid && range_error, result_value == 8'd0)
    `BIR_ASSERT_SAME(a_no_write_in_read, ram_we, !ram_re)
    `BIR_ASSERT_SAME(a_no_take_mid_reads, s2_valid_reg && !s2_last, !item_take)
endmodule
